[design/krl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krl_pkg: shared types and constants for the keyed recent-id list map
// Command and status codes, field widths and controller/datapath bundles.
// ----------------------------------------------------------------------------
package krl_pkg;

    localparam int TableEntriesDef = 64;
    localparam int ValueLenDef     = 4;
    localparam int KeyBitsDef      = 64;

    localparam int CmdW    = 2;
    localparam int KeyW    = 64;
    localparam int IdW     = 63;
    localparam int StatusW = 3;

    localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CmdW-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CmdW-1:0] CMD_DELETE = 2'd2;
    localparam logic [CmdW-1:0] CMD_RSVD   = 2'd3;   // no effect, answers ok

    localparam logic [StatusW-1:0] ST_OK    = 3'd0;
    localparam logic [StatusW-1:0] ST_NOKEY = 3'd1;
    localparam logic [StatusW-1:0] ST_NOID  = 3'd2;
    localparam logic [StatusW-1:0] ST_FULL  = 3'd3;
    localparam logic [StatusW-1:0] ST_FREED = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request fields, clear scan state
        logic scan;       // examine entry at scan index
        logic slot_rd;    // latch slot row read data
        logic alloc;      // claim free entry, clear its slots
        logic push;       // shift id in at front
        logic remove;     // compact removing hit slot
        logic out_step;   // advance lookup slot index
    } krl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic free_found;
        logic id_hit;
        logic front_left; // front slot valid after removal
        logic last_slot;
    } krl_stat_t;

endpackage

[design/krl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krl_if: valid/ready channel
// Generic handshake channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface krl_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[design/krl_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krl_dp: datapath
// Entry key store scanned one entry per cycle, slot rows held as one memory
// word per entry, and the slot list shift/compact logic.
// ----------------------------------------------------------------------------
module krl_dp #(
    parameter int TABLE_ENTRIES = krl_pkg::TableEntriesDef,
    parameter int VALUE_LEN     = krl_pkg::ValueLenDef,
    parameter int KEY_BITS      = krl_pkg::KeyBitsDef
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [krl_pkg::KeyW-1:0]    in_key,
    input  logic [krl_pkg::IdW-1:0]     in_id,
    input  krl_pkg::krl_cmd_t           cmd,
    output krl_pkg::krl_stat_t          stat,
    output logic [krl_pkg::IdW-1:0]     slot_id,
    output logic                        slot_valid
);
    localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW = (VALUE_LEN > 1) ? $clog2(VALUE_LEN) : 1;
    localparam int IdW = krl_pkg::IdW;

    logic [KEY_BITS-1:0]  keys_mem [TABLE_ENTRIES];
    logic [IdW-1:0]       ids_mem  [TABLE_ENTRIES][VALUE_LEN];
    logic [TABLE_ENTRIES-1:0] entry_used_reg;
    logic [VALUE_LEN-1:0] slot_used_reg [TABLE_ENTRIES];

    logic [KEY_BITS-1:0]  key_reg;
    logic [IdW-1:0]       id_reg;
    logic [EW:0]          scan_reg;
    logic [EW-1:0]        hit_e_reg, free_e_reg;
    logic                 found_reg, free_found_reg;
    logic [KEY_BITS-1:0]  key_rd_reg;
    logic                 key_rd_ok_reg;
    logic [EW-1:0]        key_rd_e_reg;
    logic [IdW-1:0]       row_ids_reg [VALUE_LEN];
    logic [VALUE_LEN-1:0] row_used_reg;
    logic [SW-1:0]        out_idx_reg;

    // hit slot search over the latched row (full-width id compare per lane)
    logic [VALUE_LEN-1:0] lane_hit;
    logic [VALUE_LEN-1:0] first_hit;   // one-hot
    logic [VALUE_LEN-1:0] keep_mask;   // slots before hit
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int j = 0; j < VALUE_LEN; j++)
        begin
            lane_hit[j]  = row_used_reg[j] && (row_ids_reg[j] == id_reg);
            first_hit[j] = lane_hit[j] && !seen;
            keep_mask[j] = !seen && !lane_hit[j];
            seen = seen | lane_hit[j];
        end
    end

    // compacted row
    logic [IdW-1:0]       rm_ids  [VALUE_LEN];
    logic [VALUE_LEN-1:0] rm_used;
    always_comb
    begin
        for (int j = 0; j < VALUE_LEN; j++)
        begin
            if (keep_mask[j])
            begin
                rm_ids[j]  = row_ids_reg[j];
                rm_used[j] = row_used_reg[j];
            end
            else if (j < VALUE_LEN - 1)
            begin
                rm_ids[j]  = row_ids_reg[(j + 1) % VALUE_LEN];
                rm_used[j] = row_used_reg[(j + 1) % VALUE_LEN];
            end
            else
            begin
                rm_ids[j]  = row_ids_reg[j];
                rm_used[j] = 1'b0;
            end
        end
    end

    logic [EW-1:0] scan_idx;
    assign scan_idx = scan_reg[EW-1:0];

    always_ff @(posedge clk)
    begin
        key_rd_reg <= keys_mem[scan_idx];
        if (cmd.load)
            key_reg <= in_key[KEY_BITS-1:0];
        if (cmd.load)
            id_reg <= in_id;
        if (cmd.alloc)
            keys_mem[free_e_reg] <= key_reg;
        if (cmd.slot_rd)
        begin
            for (int j = 0; j < VALUE_LEN; j++)
                row_ids_reg[j] <= ids_mem[hit_e_reg][j];
        end
        if (cmd.push)
        begin
            ids_mem[hit_e_reg][0] <= id_reg;
            for (int j = 1; j < VALUE_LEN; j++)
                ids_mem[hit_e_reg][j] <= row_ids_reg[j-1];
        end
        else if (cmd.remove)
        begin
            for (int j = 0; j < VALUE_LEN; j++)
                ids_mem[hit_e_reg][j] <= rm_ids[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_used_reg <= '0;
            for (int e = 0; e < TABLE_ENTRIES; e++)
                slot_used_reg[e] <= '0;
            scan_reg       <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            hit_e_reg      <= '0;
            free_e_reg     <= '0;
            key_rd_ok_reg  <= 1'b0;
            key_rd_e_reg   <= '0;
            row_used_reg   <= '0;
            out_idx_reg    <= '0;
        end
        else
        begin
            key_rd_ok_reg <= 1'b0;
            if (cmd.load)
            begin
                scan_reg       <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                out_idx_reg    <= '0;
            end
            else if (cmd.scan)
            begin
                // registered key read: compare the read issued on the previous scan step
                if (scan_reg < (EW+1)'(TABLE_ENTRIES))
                begin
                    key_rd_ok_reg <= 1'b1;
                    key_rd_e_reg  <= scan_idx;
                    scan_reg      <= scan_reg + 1'b1;
                    if (!entry_used_reg[scan_idx] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_e_reg     <= scan_idx;
                    end
                end
                if (key_rd_ok_reg && !found_reg && entry_used_reg[key_rd_e_reg]
                    && key_rd_reg == key_reg)
                begin
                    found_reg <= 1'b1;
                    hit_e_reg <= key_rd_e_reg;
                end
            end
            if (cmd.alloc)
            begin
                hit_e_reg                  <= free_e_reg;
                entry_used_reg[free_e_reg] <= 1'b1;
                slot_used_reg[free_e_reg]  <= '0;
            end
            if (cmd.slot_rd)
                row_used_reg <= slot_used_reg[hit_e_reg];
            if (cmd.push)
                slot_used_reg[hit_e_reg] <= VALUE_LEN'({row_used_reg, 1'b1});
            else if (cmd.remove)
            begin
                slot_used_reg[hit_e_reg] <= rm_used;
                if (!rm_used[0])
                    entry_used_reg[hit_e_reg] <= 1'b0;
            end
            if (cmd.out_step)
                out_idx_reg <= out_idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        stat.scan_done  = (scan_reg == (EW+1)'(TABLE_ENTRIES)) && !key_rd_ok_reg;
        stat.found      = found_reg;
        stat.free_found = free_found_reg;
        stat.id_hit     = |first_hit;
        stat.front_left = rm_used[0];
        stat.last_slot  = (out_idx_reg == SW'(VALUE_LEN - 1));
    end

    assign slot_valid = row_used_reg[out_idx_reg];
    assign slot_id    = row_used_reg[out_idx_reg] ? row_ids_reg[out_idx_reg] : '0;

endmodule

[design/krl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krl_ctrl: controller
// Sequences key scan, slot row read, rewrite and result emission.
// ----------------------------------------------------------------------------
module krl_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [krl_pkg::CmdW-1:0]         in_cmd,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [krl_pkg::StatusW-1:0]      out_status,
    output logic                             out_last,
    output logic                             out_slot,   // show slot fields
    output krl_pkg::krl_cmd_t                cmd,
    input  krl_pkg::krl_stat_t               stat
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_READ, S_ACT, S_LIST, S_RESP
    } state_t;

    state_t                          state_reg, state_next;
    logic [krl_pkg::CmdW-1:0]        op_reg, op_next;
    logic [krl_pkg::StatusW-1:0]     st_reg, st_next;
    logic                            last_reg, last_next;
    logic                            slot_reg, slot_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_RESP) || (state_reg == S_LIST);
    assign out_status = st_reg;
    assign out_last   = (state_reg == S_LIST) ? stat.last_slot : last_reg;
    assign out_slot   = slot_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        st_next    = st_reg;
        last_next  = last_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                slot_next = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    op_next  = in_cmd;
                    if (in_cmd == krl_pkg::CMD_LOOKUP || in_cmd == krl_pkg::CMD_UPDATE
                        || in_cmd == krl_pkg::CMD_DELETE)
                        state_next = S_SCAN;
                    else
                    begin
                        st_next    = krl_pkg::ST_OK;
                        last_next  = 1'b1;
                        state_next = S_RESP;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.scan = 1'b0;
                    if (stat.found)
                        state_next = S_READ;
                    else if (op_reg == krl_pkg::CMD_UPDATE)
                    begin
                        if (stat.free_found)
                        begin
                            cmd.alloc  = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            st_next    = krl_pkg::ST_FULL;
                            last_next  = 1'b1;
                            state_next = S_RESP;
                        end
                    end
                    else
                    begin
                        st_next    = krl_pkg::ST_NOKEY;
                        last_next  = 1'b1;
                        state_next = S_RESP;
                    end
                end
            end
            S_READ:
            begin
                cmd.slot_rd = 1'b1;
                state_next  = S_ACT;
            end
            S_ACT:
            begin
                last_next = 1'b1;
                st_next   = krl_pkg::ST_OK;
                case (op_reg)
                    krl_pkg::CMD_LOOKUP:
                    begin
                        slot_next  = 1'b1;
                        state_next = S_LIST;
                    end
                    krl_pkg::CMD_UPDATE:
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_RESP;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                        if (!stat.id_hit)
                            st_next = krl_pkg::ST_NOID;
                        else
                        begin
                            cmd.remove = 1'b1;
                            if (!stat.front_left)
                                st_next = krl_pkg::ST_FREED;
                        end
                    end
                endcase
            end
            S_LIST:
            begin
                if (out_ready)
                begin
                    cmd.out_step = 1'b1;
                    if (stat.last_slot)
                        state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= krl_pkg::CMD_LOOKUP;
            st_reg    <= krl_pkg::ST_OK;
            last_reg  <= 1'b0;
            slot_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            st_reg    <= st_next;
            last_reg  <= last_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

[design/key_to_recent_id_list_map_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_to_recent_id_list_map_top: keyed recent-id list map
// Maps keys to newest-first id lists; lookup, push and delete requests.
//
//   channel | dir | payload
//   req     | in  | command[1:0], key[63:0], id[62:0]
//   rsp     | out | status[2:0], slot_id[62:0], slot_valid, last
//
// A request runs the key scan, the slot row read and the action; a lookup
// then emits one result per slot. An absent key or a full table answers after
// the scan. The key scan reads one key store entry per cycle. Command three
// answers with no scan. Valid bits clear at reset; no clearing pass.
// Output stalls hold the block; no new request is taken until done.
// ----------------------------------------------------------------------------
module key_to_recent_id_list_map_top #(
    parameter int TABLE_ENTRIES = krl_pkg::TableEntriesDef,
    parameter int VALUE_LEN     = krl_pkg::ValueLenDef,
    parameter int KEY_BITS      = krl_pkg::KeyBitsDef
) (
    input  logic  clk,
    input  logic  rst_n,
    krl_if.sink   req,
    krl_if.source rsp
);
    localparam int KeyW = krl_pkg::KeyW;
    localparam int IdW  = krl_pkg::IdW;

    krl_pkg::krl_cmd_t  cmd;
    krl_pkg::krl_stat_t stat;
    logic [IdW-1:0]     slot_id;
    logic               slot_valid, out_slot, out_last;
    logic [krl_pkg::StatusW-1:0] out_status;

    krl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_cmd     (req.payload[KeyW+IdW +: krl_pkg::CmdW]),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (out_status),
        .out_last   (out_last),
        .out_slot   (out_slot),
        .cmd        (cmd),
        .stat       (stat)
    );

    krl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .VALUE_LEN     (VALUE_LEN),
        .KEY_BITS      (KEY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_key     (req.payload[IdW +: KeyW]),
        .in_id      (req.payload[IdW-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .slot_id    (slot_id),
        .slot_valid (slot_valid)
    );

    assign rsp.payload = {out_status,
                          out_slot ? slot_id : {IdW{1'b0}},
                          out_slot & slot_valid,
                          out_last};

endmodule
